FILE: design/rhtt_pkg.sv
`default_nettype none

package rhtt_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int COORD_W = 16;
    localparam int SIZEA_W = 16;
    localparam int SIZEB_W = 15;
    // squared distance along one axis fits in 32 bits (|d| <= 65535)
    localparam int SQ_W    = 32;
    // radius squared with the 8 fraction bits dropped
    localparam int R2H_W   = 2 * SIZEA_W - 8;

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;
    localparam logic SHAPE_RECT   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

    typedef struct packed {
        logic                      circle;
        logic                      kind;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [SIZEA_W-1:0]        size_a;
        logic [SIZEB_W-1:0]        size_b;
        logic [R2H_W-1:0]          r2h;
    } region_t;

    // query travelling down the chain, with the test of the cell above still open
    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic                      hit;
        logic [SLOT_W-1:0]         hit_slot;
        logic                      hit_kind;
        logic                      pend_valid;
        logic                      pend_circle;
        logic                      pend_rect_in;
        logic [SQ_W-1:0]           pend_sqx;
        logic [SQ_W-1:0]           pend_sqy;
        logic [R2H_W-1:0]          pend_r2h;
        logic [SLOT_W-1:0]         pend_slot;
        logic                      pend_kind;
    } token_t;

    // settle the open test; an earlier (higher) hit always wins
    function automatic token_t resolve_pending(token_t t);
        logic [SQ_W:0] d2;
        logic          covers;
        token_t        r;
        d2 = {1'b0, t.pend_sqx} + {1'b0, t.pend_sqy};
        covers = t.pend_circle ? (d2 <= {{(SQ_W + 1 - R2H_W){1'b0}}, t.pend_r2h})
                               : t.pend_rect_in;
        r = t;
        if (!t.hit && t.pend_valid && covers)
        begin
            r.hit      = 1'b1;
            r.hit_slot = t.pend_slot;
            r.hit_kind = t.pend_kind;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/rhtt_cell.sv
`default_nettype none

module rhtt_cell
    import rhtt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              load_en,
    input  wire region_t           load_region,
    input  wire logic [SLOT_W-1:0] cell_slot,
    input  wire logic              up_valid,
    input  wire token_t            up_tok,
    output logic                   down_valid,
    output token_t                 down_tok
);

    logic    region_valid_reg;
    region_t region_reg;
    logic    tok_valid_reg;
    token_t  tok_reg;
    token_t  tok_next;

    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [2*COORD_W+1:0] sqx_full;
    logic signed [2*COORD_W+1:0] sqy_full;
    logic signed [COORD_W+1:0]   x_far;
    logic signed [COORD_W+1:0]   y_far;
    logic                        rect_in;

    always_comb
    begin
        dx = {up_tok.qx[COORD_W-1], up_tok.qx} - {region_reg.ox[COORD_W-1], region_reg.ox};
        dy = {up_tok.qy[COORD_W-1], up_tok.qy} - {region_reg.oy[COORD_W-1], region_reg.oy};
        sqx_full = dx * dx;
        sqy_full = dy * dy;
        // far edges, closed
        x_far = {{2{region_reg.ox[COORD_W-1]}}, region_reg.ox}
              + $signed({2'b00, region_reg.size_a});
        y_far = {{2{region_reg.oy[COORD_W-1]}}, region_reg.oy}
              + $signed({{(COORD_W + 2 - SIZEB_W){1'b0}}, region_reg.size_b});
        rect_in = ($signed(up_tok.qx) >= $signed(region_reg.ox))
               && ($signed({{2{up_tok.qx[COORD_W-1]}}, up_tok.qx}) <= x_far)
               && ($signed(up_tok.qy) >= $signed(region_reg.oy))
               && ($signed({{2{up_tok.qy[COORD_W-1]}}, up_tok.qy}) <= y_far);

        tok_next              = resolve_pending(up_tok);
        tok_next.pend_valid   = region_valid_reg;
        tok_next.pend_circle  = region_reg.circle;
        tok_next.pend_rect_in = rect_in;
        tok_next.pend_sqx     = sqx_full[SQ_W-1:0];
        tok_next.pend_sqy     = sqy_full[SQ_W-1:0];
        tok_next.pend_r2h     = region_reg.r2h;
        tok_next.pend_slot    = cell_slot;
        tok_next.pend_kind    = region_reg.kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_valid_reg <= 1'b0;
            tok_valid_reg    <= 1'b0;
        end
        else
        begin
            if (load_en)
            begin
                region_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                tok_valid_reg <= up_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            region_reg <= load_region;
        end
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign down_valid = tok_valid_reg;
    assign down_tok   = tok_reg;

endmodule

`default_nettype wire

FILE: design/region_hit_test_table_unit.sv
`default_nettype none

// region hit test table: a row of SLOTS cells, one region per cell. a load
// transfer (action 0) writes its slot's region register; loads to slots beyond
// the table are dropped and give no result. a query transfer (action 1) enters
// the top cell and moves down one cell per cycle unless the row holds for a
// waiting result; each cell runs its rectangle compare and squares dx and dy,
// and the next cell finishes the open circle compare, so the highest
// containing slot wins. the result passes through every cell register into an
// output register and is held there until taken. only one query is in the row
// at a time: req_stall is high while it travels, so no new query or load is
// taken until it has left the cell row. loads are taken whenever the row is
// empty, even while a result waits. valid marks clear at reset; no clearing
// pass is needed.
module region_hit_test_table_unit
    import rhtt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic                      action,
    input  wire logic [SLOT_W-1:0]         slot,
    input  wire logic                      shape_kind,
    input  wire logic                      control_kind,
    input  wire logic signed [COORD_W-1:0] px,
    input  wire logic signed [COORD_W-1:0] py,
    input  wire logic [SIZEA_W-1:0]        size_a,
    input  wire logic [SIZEB_W-1:0]        size_b,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output logic                           hit,
    output logic [SLOT_W-1:0]              hit_slot,
    output logic                           hit_control_kind
);

    // chain_valid[SLOTS] / chain_tok[SLOTS] is the query entering the top cell
    logic [SLOTS:0] chain_valid;
    token_t         chain_tok [SLOTS:0];

    logic      req_fire;
    logic      load_fire;
    logic      advance;
    logic      chain_busy;
    region_t   load_region;
    logic [2*SIZEA_W-1:0] radius_sq;
    token_t    final_tok;

    logic                rsp_valid_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   hit_slot_reg;
    logic                hit_kind_reg;

    assign chain_busy = |chain_valid[SLOTS-1:0];
    assign req_stall  = chain_busy;
    assign req_fire   = req_valid && !req_stall;
    assign load_fire  = req_fire && (action == ACT_LOAD);

    // the whole row holds while a finished query waits for the output register
    assign advance = !(chain_valid[0] && rsp_valid_reg && rsp_stall);

    // radius squared once, shared by all cells
    assign radius_sq = size_a * size_a;

    always_comb
    begin
        load_region.circle = (shape_kind == SHAPE_CIRCLE);
        load_region.kind   = control_kind;
        load_region.ox     = px;
        load_region.oy     = py;
        load_region.size_a = size_a;
        load_region.size_b = size_b;
        // d2 * 256 <= r2 is the same test as d2 <= floor(r2 / 256)
        load_region.r2h    = radius_sq[2*SIZEA_W-1:8];
    end

    always_comb
    begin
        chain_tok[SLOTS]              = '0;
        chain_tok[SLOTS].qx           = px;
        chain_tok[SLOTS].qy           = py;
        chain_valid[SLOTS]            = req_fire && (action == ACT_QUERY);
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic load_sel;

        if (i < (1 << SLOT_W))
        begin : g_addr
            assign load_sel = load_fire && (slot == SLOT_W'(i));
        end
        else
        begin : g_noaddr
            assign load_sel = 1'b0;
        end

        rhtt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .load_en     (load_sel),
            .load_region (load_region),
            .cell_slot   (SLOT_W'(i)),
            .up_valid    (chain_valid[i+1]),
            .up_tok      (chain_tok[i+1]),
            .down_valid  (chain_valid[i]),
            .down_tok    (chain_tok[i])
        );
    end

    // the bottom cell's test is settled on the way into the output register
    assign final_tok = resolve_pending(chain_tok[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && chain_valid[0])
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && chain_valid[0])
        begin
            hit_reg      <= final_tok.hit;
            hit_slot_reg <= final_tok.hit_slot;
            hit_kind_reg <= final_tok.hit_kind;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign hit              = hit_reg;
    assign hit_slot         = hit_slot_reg;
    assign hit_control_kind = hit_kind_reg;

endmodule

`default_nettype wire

FILE: design/rhtt_checker.sv
`default_nettype none

module rhtt_checker
    import rhtt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic              action,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire logic              hit,
    input  wire logic [SLOT_W-1:0] hit_slot,
    input  wire logic              hit_control_kind
);

    // a query keeps the row busy on the next cycle
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (action == ACT_QUERY) |=> req_stall)
        else $error("query transfer not followed by stall");

    // a miss reports slot and kind as zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> (hit_slot == '0) && !hit_control_kind)
        else $error("miss with non-zero slot or kind");

    // a new result only comes out of a query that was travelling
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a query in flight");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(hit) && $stable(hit_slot)
            && $stable(hit_control_kind))
        else $error("stalled result changed");

endmodule

bind region_hit_test_table_unit rhtt_checker u_rhtt_checker (.*);

`default_nettype wire
